// ===== hdl/sobel_pkg.sv =====
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared constants and types: CORDIC angle table, fixed-point constants.
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int XY_W         = 34;  // |g| <= 1020, << 20, plus growth and sign
  localparam int Z_W          = 33;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [14:0] PI_Q12      = 15'd12868;
  localparam logic [14:0] HALF_PI_Q12 = 15'd6434;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    DIR_CORDIC   = 2'd0,
    DIR_ZERO     = 2'd1,
    DIR_PI       = 2'd2,
    DIR_HALF_PI  = 2'd3
  } dir_kind_t;

  // Payload carried alongside the arithmetic in every cell.
  typedef struct packed {
    logic      vld;
    logic      last;
    logic      gx_pos;
    logic      gy_neg;
    dir_kind_t kind;
  } tag_t;

  function automatic logic [Z_W-1:0] atan_q30(input logic [4:0] i);
    logic [Z_W-1:0] v;
    case (i)
      5'd0:  v = 33'h03243F6A8; 5'd1:  v = 33'h01DAC6705; 5'd2:  v = 33'h00FADBAFC;
      5'd3:  v = 33'h007F56EA6; 5'd4:  v = 33'h003FEAB76; 5'd5:  v = 33'h001FFD55B;
      5'd6:  v = 33'h000FFFAAA; 5'd7:  v = 33'h0007FFF55; 5'd8:  v = 33'h0003FFFEA;
      5'd9:  v = 33'h0001FFFFD; 5'd10: v = 33'h0000FFFFF; 5'd11: v = 33'h00007FFFF;
      5'd12: v = 33'h00003FFFF; 5'd13: v = 33'h00001FFFF; 5'd14: v = 33'h00000FFFF;
      5'd15: v = 33'h000007FFF; 5'd16: v = 33'h000003FFF; 5'd17: v = 33'h000001FFF;
      5'd18: v = 33'h000000FFF; 5'd19: v = 33'h0000007FF; 5'd20: v = 33'h0000003FF;
      5'd21: v = 33'h0000001FF; 5'd22: v = 33'h0000000FF; 5'd23: v = 33'h00000007F;
      5'd24: v = 33'h00000003F; 5'd25: v = 33'h00000001F; 5'd26: v = 33'h00000000F;
      5'd27: v = 33'h000000008; 5'd28: v = 33'h000000004; 5'd29: v = 33'h000000002;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/sobel_ram.sv =====
// ----------------------------------------------------------------------------
// sobel_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sobel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hdl/sobel_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// sobel_cordic_cell
// One vectoring micro-rotation with a fixed shift; hands on to the next cell.
// ----------------------------------------------------------------------------
module sobel_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  sobel_pkg::tag_t                tag_i,
  input  logic signed [sobel_pkg::XY_W-1:0] x_i,
  input  logic signed [sobel_pkg::XY_W-1:0] y_i,
  input  logic signed [sobel_pkg::Z_W-1:0]  z_i,
  output sobel_pkg::tag_t                tag_o,
  output logic signed [sobel_pkg::XY_W-1:0] x_o,
  output logic signed [sobel_pkg::XY_W-1:0] y_o,
  output logic signed [sobel_pkg::Z_W-1:0]  z_o
);
  import sobel_pkg::*;

  logic signed [XY_W-1:0] xs, ys;
  logic [Z_W-1:0]         ang;

  assign xs  = x_i >>> STEP;
  assign ys  = y_i >>> STEP;
  assign ang = atan_q30(5'(STEP));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_o.vld <= 1'b0;
    end else if (en) begin
      tag_o.vld <= tag_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_o.last   <= tag_i.last;
      tag_o.gx_pos <= tag_i.gx_pos;
      tag_o.gy_neg <= tag_i.gy_neg;
      tag_o.kind   <= tag_i.kind;
      if (y_i > 0) begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + $signed(ang);
      end else begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - $signed(ang);
      end
    end
  end
endmodule

// ===== hdl/sobel_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// sobel_sqrt_cell
// Resolve one root bit per cell (restoring, two radicand bits per step), passing rem/root on.
// ----------------------------------------------------------------------------
module sobel_sqrt_cell #(
  parameter int STEP = 0  // bit position weight 4^(15-STEP) handled here
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] n_i,
  input  logic [31:0] r_i,
  input  logic [31:0] q_i,
  output logic [31:0] n_o,
  output logic [31:0] r_o,
  output logic [31:0] q_o
);
  localparam logic [31:0] BIT = 32'd1 << (2 * (15 - STEP));

  logic [31:0] qb;
  assign qb = q_i + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      n_o <= n_i;
      if (r_i >= qb) begin
        r_o <= r_i - qb;
        q_o <= (q_i >> 1) + BIT;
      end else begin
        r_o <= r_i;
        q_o <= q_i >> 1;
      end
    end
  end
endmodule

// ===== hdl/sobel_edge_magnitude_direction_top.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_direction_top
// Streaming 3x3 Sobel gradient magnitude and direction.
// ----------------------------------------------------------------------------
// Feed 8-bit grayscale pixels in raster order on the in_ stream, one beat per
// pixel. Every pixel whose 3x3 window lies inside the frame gives one out_
// beat: magnitude (Q.4, rounded) and direction atan2(gy,gx) (Q.12 radians,
// rounded); border pixels give no beat. out_tlast marks the last result of
// a frame. Frame size is set over the cfg_ channel (index 0 width, 1 height);
// any write restarts the frame. Only write while the block is idle.
// Throughput is one pixel per clock while the output is not stalled. The edge
// that accepts the pixel completing its window reads the line buffers, then
// come window and gradient, squares, a chain of 30 cells in which 30 CORDIC
// micro-rotations run alongside 16 one-bit square-root cells, and the output
// register, which presents the result beat. The whole chain advances
// only when the output register is free or being taken, so a stalled
// receiver holds every stage and drops in_tready; nothing is lost. Reset
// returns to the top-left of a frame with width 640 and height 480; the line
// buffers need no clearing since rows are read only after they were written.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_direction_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [14:0] grad_magnitude, [29:15] grad_direction
  output logic        out_tlast,    // frame_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sobel_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int NCELL = CORDIC_STEPS;  // sqrt cells ride cells 0..15

  logic [11:0] width_r;
  logic [15:0] height_r;
  logic [CW-1:0] col_r;
  logic [15:0] row_r;
  logic [CW-1:0] weff;
  logic [15:0]   heff;
  logic adv, take;

  // Clamp width to [3, MAX_WIDTH] and height to at least 3.
  always_comb begin
    if (width_r < 12'd3) weff = CW'(3);
    else if ({20'd0, width_r} > MAX_WIDTH) weff = CW'(MAX_WIDTH);
    else weff = CW'(width_r);
    heff = (height_r < 16'd3) ? 16'd3 : height_r;
  end

  assign cfg_ready = 1'b1;
  assign in_tready = adv;
  assign take      = in_tvalid && adv;

  // Frame position and registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 16'd480;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) width_r <= cfg_data[11:0];
      else height_r <= cfg_data;
      col_r <= '0;
      row_r <= '0;
    end else if (take) begin
      if (col_r + CW'(1) >= weff) begin
        col_r <= '0;
        row_r <= (row_r + 16'd1 >= heff) ? 16'd0 : row_r + 16'd1;
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Two row banks; bank selected by row parity.
  logic [7:0] rd0, rd1;
  logic [AW-1:0] caddr;
  assign caddr = col_r[AW-1:0];

  sobel_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_bank0 (
    .clk, .we(take && !row_r[0]), .waddr(caddr), .wdata(in_tdata),
    .re(take), .raddr(caddr), .rdata(rd0));
  sobel_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_bank1 (
    .clk, .we(take && row_r[0]), .waddr(caddr), .wdata(in_tdata),
    .re(take), .raddr(caddr), .rdata(rd1));

  // Stage A: pixel, parity and flags alongside the RAM read.
  logic       a_vld_r, a_emit_r, a_last_r, a_par_r;
  logic [7:0] a_pix_r;
  logic [7:0] win_r [3][2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_pix_r  <= in_tdata;
      a_par_r  <= row_r[0];
      a_emit_r <= (row_r >= 16'd2) && (col_r >= CW'(2));
      a_last_r <= (row_r == heff - 16'd1) && (col_r == weff - CW'(1));
    end
  end

  // Stage B: window update and gradients.
  logic [7:0] p02, p12;
  logic signed [11:0] gx, gy;
  assign p02 = a_par_r ? rd1 : rd0;
  assign p12 = a_par_r ? rd0 : rd1;
  assign gx = (12'(p02) + {3'd0, p12, 1'b0} + 12'(a_pix_r))
            - (12'(win_r[0][0]) + {3'd0, win_r[1][0], 1'b0} + 12'(win_r[2][0]));
  assign gy = (12'(win_r[2][0]) + {3'd0, win_r[2][1], 1'b0} + 12'(a_pix_r))
            - (12'(win_r[0][0]) + {3'd0, win_r[0][1], 1'b0} + 12'(p02));

  logic              b_vld_r, b_last_r;
  logic signed [11:0] gx_r, gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= '0;
        win_r[k][1] <= '0;
      end
    end else if (adv) begin
      b_vld_r <= a_vld_r && a_emit_r;
      if (a_vld_r) begin
        win_r[0][0] <= win_r[0][1]; win_r[0][1] <= p02;
        win_r[1][0] <= win_r[1][1]; win_r[1][1] <= p12;
        win_r[2][0] <= win_r[2][1]; win_r[2][1] <= a_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gx_r     <= gx;
      gy_r     <= gy;
      b_last_r <= a_last_r;
    end
  end

  // Stage C: squares, CORDIC start values, direction kind.
  logic [10:0] agx, agy;
  assign agx = gx_r[11] ? 11'(-gx_r) : 11'(gx_r);
  assign agy = gy_r[11] ? 11'(-gy_r) : 11'(gy_r);

  tag_t               c_tag_r;
  logic [31:0]        c_sq_r;
  logic signed [XY_W-1:0] c_x_r, c_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_tag_r.vld <= 1'b0;
    end else if (adv) begin
      c_tag_r.vld <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_tag_r.last   <= b_last_r;
      c_tag_r.gx_pos <= (gx_r > 0);
      c_tag_r.gy_neg <= gy_r[11];
      if (gy_r == 0) c_tag_r.kind <= gx_r[11] ? DIR_PI : DIR_ZERO;
      else if (gx_r == 0) c_tag_r.kind <= DIR_HALF_PI;
      else c_tag_r.kind <= DIR_CORDIC;
      c_sq_r <= ({10'd0, 22'(agx) * 22'(agx)} + {10'd0, 22'(agy) * 22'(agy)}) << 8;
      c_x_r  <= $signed({3'd0, agx, 20'd0});
      c_y_r  <= $signed({3'd0, agy, 20'd0});
    end
  end

  // Cell chain: CORDIC in every cell, square root in the first sixteen.
  tag_t               tg [NCELL+1];
  logic signed [XY_W-1:0] cx [NCELL+1];
  logic signed [XY_W-1:0] cy [NCELL+1];
  logic signed [Z_W-1:0]  cz [NCELL+1];
  logic [14:0]        mg_rnd;
  logic [14:0]        mg [NCELL-16];
  logic [31:0]        sn [17];
  logic [31:0]        sr [17];
  logic [31:0]        sq [17];

  assign tg[0] = c_tag_r;
  assign cx[0] = c_x_r;
  assign cy[0] = c_y_r;
  assign cz[0] = '0;
  assign mg_rnd = (sn[16] > sq[16] * sq[16] + sq[16]) ? 15'(sq[16] + 32'd1)
                                                      : 15'(sq[16]);
  assign sn[0] = c_sq_r;
  assign sr[0] = c_sq_r;
  assign sq[0] = '0;

  for (genvar i = 0; i < 16; i++) begin : g_sqrt
    sobel_sqrt_cell #(.STEP(i)) u_sq (
      .clk, .en(adv), .n_i(sn[i]), .r_i(sr[i]), .q_i(sq[i]),
      .n_o(sn[i+1]), .r_o(sr[i+1]), .q_o(sq[i+1]));
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cordic
    sobel_cordic_cell #(.STEP(i)) u_cell (
      .clk, .rst_n, .en(adv), .tag_i(tg[i]), .x_i(cx[i]), .y_i(cy[i]),
      .z_i(cz[i]), .tag_o(tg[i+1]), .x_o(cx[i+1]), .y_o(cy[i+1]),
      .z_o(cz[i+1]));
  end

  // Carry the rounded root beside the last fourteen CORDIC cells.
  always_ff @(posedge clk) begin
    if (adv) begin
      mg[0] <= mg_rnd;
      for (int k = 1; k < NCELL - 16; k++) begin
        mg[k] <= mg[k-1];
      end
    end
  end

  // Final: fold into [0,pi], round to Q.12, apply sign.
  tag_t              ft;
  logic signed [34:0] t, tr;
  logic [14:0]       rq, dir;
  assign ft = tg[NCELL];
  assign t  = ft.gx_pos ? 35'(cz[NCELL]) : $signed({3'd0, PI_Q30}) - 35'(cz[NCELL]);
  assign tr = (t + 35'sd131072) >>> 18;
  assign rq = tr[14:0];

  always_comb begin
    case (ft.kind)
      DIR_ZERO:    dir = 15'd0;
      DIR_PI:      dir = PI_Q12;
      DIR_HALF_PI: dir = ft.gy_neg ? 15'(-HALF_PI_Q12) : HALF_PI_Q12;
      default:     dir = ft.gy_neg ? 15'(-rq) : rq;
    endcase
  end

  // Output register: advance when empty or being taken.
  assign adv = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (adv) begin
      out_tvalid <= ft.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata <= {2'b00, dir, mg[NCELL-17]};
      out_tlast <= ft.last;
    end
  end
endmodule
